// File: sv/mtsf_pkg.sv
package mtsf_pkg;

    // Default longest target, in bytes
    localparam int MAX_TARGET_LEN_DEF = 8;

    // Configuration port geometry: five registers, 64-bit data, 8-byte stride
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_LSB = 3;

    // Target text and length widths
    localparam int TEXT_W = 64;
    localparam int LEN_W = 4;

    // Register map
    typedef enum logic [2:0] {
        REG_FIRST_TEXT  = 3'd0,
        REG_FIRST_LEN   = 3'd1,
        REG_SECOND_TEXT = 3'd2,
        REG_SECOND_LEN  = 3'd3,
        REG_USE_SECOND  = 3'd4
    } t_reg_idx;

    // Result codes
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_MATCHED   = 2'd1,
        ST_TIMEOUT   = 2'd2
    } t_status;

    // Settings as seen by the sequencer
    typedef struct packed {
        logic [TEXT_W-1:0] first_text;
        logic [LEN_W-1:0]  first_len;
        logic [TEXT_W-1:0] second_text;
        logic [LEN_W-1:0]  second_len;
        logic              use_second;
    } t_cfg;

    // Input beat
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       read_timed_out;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [1:0] search_status;
        logic       matched_target;
    } t_out_item;

endpackage

// File: sv/mtsf_regs.sv
module mtsf_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mtsf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [mtsf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [mtsf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output mtsf_pkg::t_cfg                       o_cfg
);

    mtsf_pkg::t_cfg   r_cfg;
    mtsf_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = mtsf_pkg::t_reg_idx'(paddr[mtsf_pkg::CFG_ADDR_W-1:mtsf_pkg::CFG_IDX_LSB]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Hold register contents, write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_text  <= '0;
            r_cfg.first_len   <= mtsf_pkg::LEN_W'(1);
            r_cfg.second_text <= '0;
            r_cfg.second_len  <= mtsf_pkg::LEN_W'(1);
            r_cfg.use_second  <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                mtsf_pkg::REG_FIRST_TEXT:  r_cfg.first_text  <= pwdata;
                mtsf_pkg::REG_FIRST_LEN:   r_cfg.first_len   <= pwdata[mtsf_pkg::LEN_W-1:0];
                mtsf_pkg::REG_SECOND_TEXT: r_cfg.second_text <= pwdata;
                mtsf_pkg::REG_SECOND_LEN:  r_cfg.second_len  <= pwdata[mtsf_pkg::LEN_W-1:0];
                mtsf_pkg::REG_USE_SECOND:  r_cfg.use_second  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            mtsf_pkg::REG_FIRST_TEXT:  prdata = r_cfg.first_text;
            mtsf_pkg::REG_FIRST_LEN:   prdata[mtsf_pkg::LEN_W-1:0] = r_cfg.first_len;
            mtsf_pkg::REG_SECOND_TEXT: prdata = r_cfg.second_text;
            mtsf_pkg::REG_SECOND_LEN:  prdata[mtsf_pkg::LEN_W-1:0] = r_cfg.second_len;
            mtsf_pkg::REG_USE_SECOND:  prdata[0] = r_cfg.use_second;
            default: prdata = '0;
        endcase
    end

endmodule

// File: sv/mtsf_prefix_cmp.sv
module mtsf_prefix_cmp #(
    parameter int MAX_TARGET_LEN = mtsf_pkg::MAX_TARGET_LEN_DEF
) (
    input  logic [mtsf_pkg::TEXT_W-1:0] i_text,
    input  logic [7:0]                  i_byte,
    input  logic [2:0]                  i_pos,
    input  logic [2:0]                  i_orig,
    output logic                        o_byte_eq,
    output logic                        o_prefix_eq
);

    logic [2:0]                  w_diff;
    logic [mtsf_pkg::TEXT_W-1:0] w_shifted;

    // Compare the incoming byte with target byte at the probe position
    assign o_byte_eq = (i_text[{i_pos, 3'b000} +: 8] == i_byte);

    // Slide the target down by the fallback distance
    assign w_diff    = i_orig - i_pos;
    assign w_shifted = i_text >> {w_diff, 3'b000};

    // Check that the shorter prefix agrees with the tail of the longer one
    always_comb begin
        o_prefix_eq = 1'b1;
        for (int i = 0; i < MAX_TARGET_LEN; i++) begin
            if ((3'(i) < i_pos) && (i_text[8*i +: 8] != w_shifted[8*i +: 8])) begin
                o_prefix_eq = 1'b0;
            end
        end
    end

endmodule

// File: sv/mtsf_seq.sv
module mtsf_seq #(
    parameter int MAX_TARGET_LEN = mtsf_pkg::MAX_TARGET_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtsf_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mtsf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mtsf_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ADV,
        S_FALL,
        S_DONE
    } t_state;

    localparam logic [mtsf_pkg::LEN_W-1:0] MaxLen = mtsf_pkg::LEN_W'(MAX_TARGET_LEN);

    t_state                      r_state;
    logic [7:0]                  r_byte;
    logic                        r_tmo;
    logic                        r_tgt;
    logic [2:0]                  r_orig;
    logic [2:0]                  r_cand;
    logic [3:0]                  r_idx0;
    logic [3:0]                  r_idx1;
    logic [1:0]                  r_status;
    logic                        r_which;
    logic                        r_out_valid;
    mtsf_pkg::t_out_item         r_out;

    logic [mtsf_pkg::LEN_W-1:0]  w_len0;
    logic [mtsf_pkg::LEN_W-1:0]  w_len1;
    logic                        w_two;
    logic [mtsf_pkg::TEXT_W-1:0] w_text;
    logic [mtsf_pkg::LEN_W-1:0]  w_len;
    logic [3:0]                  w_idx_raw;
    logic [3:0]                  w_idx;
    logic [3:0]                  w_idx_inc;
    logic [3:0]                  w_cand_inc;
    logic [2:0]                  w_pos;
    logic                        w_byte_eq;
    logic                        w_prefix_eq;
    logic                        w_next_tgt;

    // Clamp lengths to the longest supported target
    assign w_len0 = (i_cfg.first_len > MaxLen) ? MaxLen : i_cfg.first_len;
    assign w_len1 = (i_cfg.second_len > MaxLen) ? MaxLen : i_cfg.second_len;
    assign w_two  = i_cfg.use_second;

    // Select the target under work; a stale index starts over
    assign w_text     = r_tgt ? i_cfg.second_text : i_cfg.first_text;
    assign w_len      = r_tgt ? w_len1 : w_len0;
    assign w_idx_raw  = r_tgt ? r_idx1 : r_idx0;
    assign w_idx      = (w_idx_raw >= w_len) ? 4'd0 : w_idx_raw;
    assign w_idx_inc  = w_idx + 4'd1;
    assign w_cand_inc = {1'b0, r_cand} + 4'd1;
    assign w_pos      = (r_state == S_FALL) ? r_cand : w_idx[2:0];
    assign w_next_tgt = !r_tgt && w_two;

    mtsf_prefix_cmp #(
        .MAX_TARGET_LEN (MAX_TARGET_LEN)
    ) u_cmp (
        .i_text      (w_text),
        .i_byte      (r_byte),
        .i_pos       (w_pos),
        .i_orig      (r_orig),
        .o_byte_eq   (w_byte_eq),
        .o_prefix_eq (w_prefix_eq)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer: one probe of the shared compare unit per cycle while advancing or falling back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tgt       <= 1'b0;
            r_idx0      <= 4'd0;
            r_idx1      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output beat once taken; the done state reloads it itself
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_byte  <= i_in_data.stream_byte;
                        r_tmo   <= i_in_data.read_timed_out;
                        r_state <= S_START;
                    end
                end

                // Empty targets and timeout take priority over the byte
                S_START: begin
                    r_tgt <= 1'b0;
                    if (w_len0 == '0) begin
                        r_status <= mtsf_pkg::ST_MATCHED;
                        r_which  <= 1'b0;
                        r_idx0   <= 4'd0;
                        r_idx1   <= 4'd0;
                        r_state  <= S_DONE;
                    end else if (w_two && (w_len1 == '0)) begin
                        r_status <= mtsf_pkg::ST_MATCHED;
                        r_which  <= 1'b1;
                        r_idx0   <= 4'd0;
                        r_idx1   <= 4'd0;
                        r_state  <= S_DONE;
                    end else if (r_tmo) begin
                        r_status <= mtsf_pkg::ST_TIMEOUT;
                        r_which  <= 1'b0;
                        r_idx0   <= 4'd0;
                        r_idx1   <= 4'd0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_ADV;
                    end
                end

                // Try to extend the current match
                S_ADV: begin
                    if (w_byte_eq && (w_idx_inc == w_len)) begin
                        r_status <= mtsf_pkg::ST_MATCHED;
                        r_which  <= r_tgt;
                        r_idx0   <= 4'd0;
                        r_idx1   <= 4'd0;
                        r_state  <= S_DONE;
                    end else if (w_byte_eq || (w_idx == 4'd0)) begin
                        if (r_tgt) begin
                            r_idx1 <= w_byte_eq ? w_idx_inc : 4'd0;
                        end else begin
                            r_idx0 <= w_byte_eq ? w_idx_inc : 4'd0;
                        end
                        if (w_next_tgt) begin
                            r_tgt   <= 1'b1;
                            r_state <= S_ADV;
                        end else begin
                            r_status <= mtsf_pkg::ST_SEARCHING;
                            r_which  <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_orig  <= w_idx[2:0];
                        r_cand  <= w_idx[2:0] - 3'd1;
                        r_state <= S_FALL;
                    end
                end

                // Walk shorter prefixes down until one agrees with the input
                S_FALL: begin
                    if ((w_byte_eq && w_prefix_eq) || (r_cand == 3'd0)) begin
                        if (r_tgt) begin
                            r_idx1 <= w_byte_eq ? w_cand_inc : 4'd0;
                        end else begin
                            r_idx0 <= w_byte_eq ? w_cand_inc : 4'd0;
                        end
                        if (w_next_tgt) begin
                            r_tgt   <= 1'b1;
                            r_state <= S_ADV;
                        end else begin
                            r_status <= mtsf_pkg::ST_SEARCHING;
                            r_which  <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_cand <= r_cand - 3'd1;
                    end
                end

                // Hand the result to the output register once it is free
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.search_status  <= r_status;
                        r_out.matched_target <= r_which;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/multi_target_stream_finder_core.sv
// One item in flight at a time: the input stalls from acceptance until the result
// is handed to the output register. A miss starts the fallback walk: one candidate
// prefix per cycle through the shared shift-compare unit, up to 7 per target,
// targets taken in turn.
// Reset (synchronous, active low) clears both match indices, restores register defaults
// and empties the output register.
module multi_target_stream_finder_core #(
    parameter int MAX_TARGET_LEN = mtsf_pkg::MAX_TARGET_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtsf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mtsf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mtsf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mtsf_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mtsf_pkg::t_out_item             o_out_data
);

    mtsf_pkg::t_cfg w_cfg;

    // Register file
    mtsf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Match sequencer
    mtsf_seq #(
        .MAX_TARGET_LEN (MAX_TARGET_LEN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: dv/multi_target_stream_finder_core_test.sv
`timescale 1ns / 100ps

module multi_target_stream_finder_core_test;

    localparam int LONGEST      = mtsf_pkg::MAX_TARGET_LEN_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int CHUNK_BEATS  = 33;
    localparam int CHUNKS       = 7;
    localparam int DRAIN_CYCLES = 30;
    localparam int PLAN_ROWS    = 34;

    typedef enum logic {
        ROW_BEAT  = 1'b0,
        ROW_WRITE = 1'b1
    } t_row_kind;

    // One line of the directed plan: either a register write or a stream beat
    typedef struct packed {
        t_row_kind            kind;
        mtsf_pkg::t_reg_idx   addr_idx;
        logic [63:0]          value;
        mtsf_pkg::t_in_item   beat;
        logic                 typed;
        mtsf_pkg::t_out_item  want;
    } t_plan_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [mtsf_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [mtsf_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [mtsf_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    mtsf_pkg::t_in_item              i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    mtsf_pkg::t_out_item             o_out_data;

    // Shadow of the register file and of the per-target match progress
    mtsf_pkg::t_cfg      target_cfg;
    int                  first_progress;
    int                  second_progress;
    mtsf_pkg::t_out_item expected_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int mismatches;
    int beats_sent;
    int timeouts_sent;
    int writes_done;
    int matches_seen;

    // Directed plan: typed results only where they follow at a glance
    t_plan_row directed_plan [PLAN_ROWS] = '{
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT, 64'h0, '{8'h00, 1'b0}, 1'b1,
          '{mtsf_pkg::ST_MATCHED, 1'b0}},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT, 64'h0, '{8'hFF, 1'b0}, 1'b1,
          '{mtsf_pkg::ST_SEARCHING, 1'b0}},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT, 64'h0, '{8'hFF, 1'b1}, 1'b1,
          '{mtsf_pkg::ST_TIMEOUT, 1'b0}},
        '{ROW_WRITE, mtsf_pkg::REG_FIRST_TEXT,  64'h4341_4241_4241_4241, '0, 1'b0, '0},
        '{ROW_WRITE, mtsf_pkg::REG_FIRST_LEN,   64'd8, '0, 1'b0, '0},
        // repeating pattern forces the fallback walk once before the match
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h43, 1'b0}, 1'b0, '0},
        // empty target wins even over a timeout
        '{ROW_WRITE, mtsf_pkg::REG_FIRST_LEN,   64'd0, '0, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT, 64'h0, '{8'h41, 1'b1}, 1'b1,
          '{mtsf_pkg::ST_MATCHED, 1'b0}},
        // oversized length clamps; empty terminator matches as target one
        '{ROW_WRITE, mtsf_pkg::REG_FIRST_LEN,   64'd15, '0, 1'b0, '0},
        '{ROW_WRITE, mtsf_pkg::REG_USE_SECOND,  64'd1, '0, 1'b0, '0},
        '{ROW_WRITE, mtsf_pkg::REG_SECOND_LEN,  64'd0, '0, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT, 64'h0, '{8'h43, 1'b0}, 1'b1,
          '{mtsf_pkg::ST_MATCHED, 1'b1}},
        '{ROW_WRITE, mtsf_pkg::REG_SECOND_TEXT, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
        '{ROW_WRITE, mtsf_pkg::REG_SECOND_LEN,  64'd2, '0, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'hFF, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'hFF, 1'b0}, 1'b0, '0},
        // shrink the first target mid-search so its index falls out of range
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, mtsf_pkg::REG_FIRST_LEN,   64'd3, '0, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h42, 1'b0}, 1'b0, '0},
        '{ROW_BEAT,  mtsf_pkg::REG_FIRST_TEXT,  64'h0, '{8'h41, 1'b0}, 1'b0, '0}
    };

    multi_target_stream_finder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_len(input logic [mtsf_pkg::LEN_W-1:0] len);
        return (len > LONGEST) ? LONGEST : int'(len);
    endfunction

    function automatic logic [7:0] text_byte(input logic [mtsf_pkg::TEXT_W-1:0] text,
                                             input int k);
        return text[8 * (k % 8) +: 8];
    endfunction

    // Advance one target by one byte; on a miss fall back to the longest
    // shorter prefix still consistent with the input. True on completion.
    function automatic bit target_step(input logic [mtsf_pkg::TEXT_W-1:0] text,
                                       input int len, inout int idx, input logic [7:0] c);
        int  orig;
        int  gap;
        int  i;
        bit  agree;
        if (idx >= len)
            idx = 0;
        if (c == text_byte(text, idx)) begin
            idx++;
            return idx == len;
        end
        if (idx == 0)
            return 1'b0;
        orig = idx;
        while (idx > 0) begin
            idx--;
            if (c == text_byte(text, idx)) begin
                if (idx == 0) begin
                    idx = 1;
                    break;
                end
                gap = orig - idx;
                agree = 1'b1;
                for (i = 0; i < idx; i++)
                    if (text_byte(text, i) != text_byte(text, i + gap))
                        agree = 1'b0;
                if (agree) begin
                    idx++;
                    break;
                end
            end
        end
        return 1'b0;
    endfunction

    // Expected result of one accepted beat; updates the match progress
    function automatic mtsf_pkg::t_out_item finder_step(input mtsf_pkg::t_in_item beat);
        mtsf_pkg::t_out_item res;
        int                  len0;
        int                  len1;
        bit                  both;
        len0 = eff_len(target_cfg.first_len);
        len1 = eff_len(target_cfg.second_len);
        both = target_cfg.use_second;
        res  = '{mtsf_pkg::ST_SEARCHING, 1'b0};
        if (len0 == 0)
            res = '{mtsf_pkg::ST_MATCHED, 1'b0};
        else if (both && len1 == 0)
            res = '{mtsf_pkg::ST_MATCHED, 1'b1};
        else if (beat.read_timed_out)
            res = '{mtsf_pkg::ST_TIMEOUT, 1'b0};
        else if (target_step(target_cfg.first_text, len0, first_progress, beat.stream_byte))
            res = '{mtsf_pkg::ST_MATCHED, 1'b0};
        else if (both && target_step(target_cfg.second_text, len1, second_progress,
                                     beat.stream_byte))
            res = '{mtsf_pkg::ST_MATCHED, 1'b1};
        if (res.search_status != mtsf_pkg::ST_SEARCHING) begin
            first_progress  = 0;
            second_progress = 0;
        end
        return res;
    endfunction

    // Register write: setup then access phase; called at a falling edge
    task automatic cfg_write(input mtsf_pkg::t_reg_idx idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = mtsf_pkg::CFG_ADDR_W'(idx) << mtsf_pkg::CFG_IDX_LSB;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        unique case (idx)
            mtsf_pkg::REG_FIRST_TEXT:  target_cfg.first_text  = value;
            mtsf_pkg::REG_FIRST_LEN:   target_cfg.first_len   = value[mtsf_pkg::LEN_W-1:0];
            mtsf_pkg::REG_SECOND_TEXT: target_cfg.second_text = value;
            mtsf_pkg::REG_SECOND_LEN:  target_cfg.second_len  = value[mtsf_pkg::LEN_W-1:0];
            mtsf_pkg::REG_USE_SECOND:  target_cfg.use_second  = value[0];
            default: ;
        endcase
        writes_done++;
    endtask

    // Drop valid and hold until every expected beat has come out
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Offer one beat after a random gap; record its expectation on acceptance
    task automatic send_beat(input mtsf_pkg::t_in_item beat, input bit typed,
                             input mtsf_pkg::t_out_item want);
        mtsf_pkg::t_out_item predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = beat;
        do @(posedge i_clk); while (o_in_stall);
        predicted = finder_step(beat);
        expected_results.push_back(typed ? want : predicted);
        beats_sent++;
        if (beat.read_timed_out)
            timeouts_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit tmo);
        send_beat('{b, tmo}, 1'b0, '0);
    endtask

    // Mostly letters from a tiny alphabet so that partial matches recur
    function automatic logic [7:0] pick_letter();
        return ($urandom_range(99) < 75) ? 8'(8'h61 + $urandom_range(2))
                                         : 8'($urandom_range(255));
    endfunction

    function automatic logic [63:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 64'd0;
        if (r < 10)
            return 64'($urandom_range(15, LONGEST + 1));
        return 64'($urandom_range(LONGEST, 1));
    endfunction

    task automatic random_settings();
        logic [63:0] t0;
        logic [63:0] t1;
        int          k;
        for (k = 0; k < 8; k++) begin
            t0[8 * k +: 8] = pick_letter();
            t1[8 * k +: 8] = pick_letter();
        end
        cfg_write(mtsf_pkg::REG_FIRST_TEXT, t0);
        cfg_write(mtsf_pkg::REG_FIRST_LEN, pick_length());
        cfg_write(mtsf_pkg::REG_SECOND_TEXT, t1);
        cfg_write(mtsf_pkg::REG_SECOND_LEN, pick_length());
        cfg_write(mtsf_pkg::REG_USE_SECOND, 64'($urandom_range(99) < 60));
    endtask

    // Runs along a target with random cut-offs, plus noise and timeouts
    task automatic random_stream(input int n);
        int          sent;
        int          r;
        int          k;
        int          len;
        int          run;
        logic [63:0] text;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 65) begin
                if (r < 45 || !target_cfg.use_second) begin
                    text = target_cfg.first_text;
                    len  = eff_len(target_cfg.first_len);
                end else begin
                    text = target_cfg.second_text;
                    len  = eff_len(target_cfg.second_len);
                end
                run = (len == 0) ? 1 : ($urandom_range(1) ? len : $urandom_range(len, 1));
                for (k = 0; k < run && sent < n; k++) begin
                    send_byte(text_byte(text, k), 1'b0);
                    sent++;
                end
            end else begin
                if (r < 90)
                    send_byte(pick_letter(), 1'b0);
                else if (r < 95)
                    send_byte(8'($urandom_range(255)), 1'b0);
                else
                    send_byte(8'($urandom_range(255)), 1'b1);
                sent++;
            end
        end
    endtask

    // Receiver back-pressure, changed at the falling edge
    always @(negedge i_clk)
        i_out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

    // Compare each delivered beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        mtsf_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d target %0d",
                         $time, o_out_data.search_status, o_out_data.matched_target);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.search_status !== want.search_status) begin
                    $display("%0t: search_status expected %0d actual %0d",
                             $time, want.search_status, o_out_data.search_status);
                    mismatches++;
                end
                if (o_out_data.matched_target !== want.matched_target) begin
                    $display("%0t: matched_target expected %0d actual %0d",
                             $time, want.matched_target, o_out_data.matched_target);
                    mismatches++;
                end
                if (o_out_data.search_status == mtsf_pkg::ST_MATCHED)
                    matches_seen++;
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int send_pct [3];
        int recv_pct [3];
        int p;
        int c;
        int row;
        send_pct = '{19, 81, 0};
        recv_pct = '{81, 19, 0};
        target_cfg = '{64'h0, 4'd1, 64'h0, 4'd1, 1'b0};
        first_progress  = 0;
        second_progress = 0;
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed plan
        for (row = 0; row < PLAN_ROWS; row++) begin
            if (directed_plan[row].kind == ROW_WRITE) begin
                drain_results();
                cfg_write(directed_plan[row].addr_idx, directed_plan[row].value);
            end else begin
                send_beat(directed_plan[row].beat, directed_plan[row].typed,
                          directed_plan[row].want);
            end
        end

        // Random part, three idling regimes, fresh settings per chunk
        for (p = 0; p < 3; p++) begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            for (c = 0; c < CHUNKS; c++) begin
                drain_results();
                random_settings();
                random_stream(CHUNK_BEATS);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d stream beats (%0d read timeouts) across %0d register writes;",
                 beats_sent, timeouts_sent, writes_done);
        $display("saw %0d target matches under three back-pressure regimes.", matches_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: multi_target_stream_finder_core.f
sv/mtsf_pkg.sv
sv/mtsf_regs.sv
sv/mtsf_prefix_cmp.sv
sv/mtsf_seq.sv
sv/multi_target_stream_finder_core.sv
dv/multi_target_stream_finder_core_test.sv
